// ===== src/assert_macros.svh =====
// Assertion macros shared by the save-memory responder RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is high.
`define CBSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CBSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/cbsr_pkg.sv =====
// Shared constants and types for the cartridge bus save-memory responder.
// No dependencies.
`default_nettype none

package cbsr_pkg;

   localparam int unsigned SAVE_HALFWORDS_DEF = 16384;

   localparam int WORD_W   = 32;
   localparam int HALF_W   = 16;
   localparam int OFFSET_W = 23;   // address bits 23:1 select a halfword

   localparam logic [WORD_W-1:0] HDR_ADDR_FIRST  = 32'h1000_0000;
   localparam logic [WORD_W-1:0] HDR_ADDR_SECOND = 32'h1000_0002;
   localparam logic [WORD_W-1:0] ADDR_STEP       = 32'd2;
   // 0x08000000..0x0FFFFFFF: bits 31:27 equal 5'b00001
   localparam logic [4:0]        SAVE_TAG        = 5'b00001;

   localparam logic [HALF_W-1:0] HEADER_FIRST_RST  = 16'h8037;
   localparam logic [HALF_W-1:0] HEADER_SECOND_RST = 16'hFF40;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SECOND = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== src/cbsr_mod_unit.sv =====
// Two-stage reduction of a halfword offset modulo the save memory depth.
// Reciprocal multiply, then multiply-back with one correction. Uses cbsr_pkg.
`default_nettype none

module cbsr_mod_unit import cbsr_pkg::*; #(
   parameter int unsigned DEPTH = SAVE_HALFWORDS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       stage_a_en,
   input  wire logic                       stage_b_en,
   input  wire logic [OFFSET_W-1:0]        offset,
   output logic      [$clog2(DEPTH)-1:0]   rem
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int RECIP_W = 33 - $clog2(DEPTH);
   localparam int PROD_W  = OFFSET_W + RECIP_W;
   localparam int Q_W     = PROD_W - 32;
   localparam int NW      = OFFSET_W + 1;
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(64'h1_0000_0000 / 64'(DEPTH));
   localparam logic [NW-1:0]      DIVISOR = NW'(DEPTH);

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [OFFSET_W-1:0] off_b_ff, off_c_ff;
   logic [OFFSET_W-1:0] qn_ff, qn_in;
   logic [Q_W-1:0]      q_est;
   logic [2*NW-1:0]     qn_full;
   logic [NW-1:0]       r_raw, r_fix;

   // Quotient estimate is exact or one low.
   assign prod_in = {{RECIP_W{1'b0}}, offset} * {{OFFSET_W{1'b0}}, RECIP};
   assign q_est   = prod_ff[PROD_W-1:32];
   assign qn_full = {{(2*NW-Q_W){1'b0}}, q_est} * {{NW{1'b0}}, DIVISOR};
   assign qn_in   = qn_full[OFFSET_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_a_en) begin
         prod_ff  <= prod_in;
         off_b_ff <= offset;
      end
      if (stage_b_en) begin
         qn_ff    <= qn_in;
         off_c_ff <= off_b_ff;
      end
   end

   assign r_raw = {1'b0, off_c_ff - qn_ff};
   assign r_fix = (r_raw >= DIVISOR) ? (r_raw - DIVISOR) : r_raw;
   assign rem   = r_fix[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== src/cbsr_save_mem.sv =====
// Halfword save memory with a clearing sweep after reset.
// Single address port, registered read. Uses cbsr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbsr_save_mem import cbsr_pkg::*; #(
   parameter int unsigned DEPTH = SAVE_HALFWORDS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mem_ctl_type              ctl,
   input  wire logic [$clog2(DEPTH)-1:0] idx,
   input  wire logic [HALF_W-1:0]        wr_data,
   output logic      [HALF_W-1:0]        rd_data,
   output logic                          busy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

   logic [HALF_W-1:0] save_mem_ff [DEPTH];
   logic [HALF_W-1:0] rd_data_ff;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;

   assign clr_idx_in = clr_idx_ff + IDX_W'(1);
   assign busy_in    = busy_ff && (clr_idx_ff != IDX_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         busy_ff    <= busy_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         save_mem_ff[clr_idx_ff] <= '0;
      end else if (ctl.wr_en) begin
         save_mem_ff[idx] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= save_mem_ff[idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

   `CBSR_ASSERT(a_clear_runs, busy_ff && clr_idx_ff != IDX_LAST |=> busy_ff, "clear sweep stopped early")
   `CBSR_ASSERT(a_clear_once, !busy_ff |=> !busy_ff, "clear sweep restarted without reset")

endmodule

`default_nettype wire

// ===== src/cartridge_bus_sram_responder.sv =====
// Cartridge bus save-memory responder, top level. Uses cbsr_pkg, cbsr_mod_unit,
// cbsr_save_mem and assert_macros.svh.
//
// req_* carries one raw 32-bit bus word per beat. Halfwords are swapped, then:
// bit 0 set writes the upper halfword at the latched address and steps it by 2;
// another nonzero word latches a new address; zero is a read. A read at either
// header address answers with the header CSR, in 0x08000000..0x0FFFFFFF with the
// stored halfword, elsewhere with nothing; the address steps by 2 in all cases.
// rsp_* carries one 16-bit halfword per answered read.
// csr_we/csr_index/csr_wdata write header_first (index 0) or header_second (1).
// Throughput is one beat per cycle while no clear sweep runs and no read answer
// waits on a stalled receiver. A read answer reaches rsp_tvalid through the input
// register, two modulo-reduction stages of the address-to-index path, then the
// memory read register. After reset the save memory is swept to zero, one entry
// per cycle; req_tready stays low until it is done.
// When the receiver stalls, the answer holds in the output register and the
// pipeline keeps filling; beats that give no answer still pass through.
`default_nettype none
`include "assert_macros.svh"

module cartridge_bus_sram_responder import cbsr_pkg::*; #(
   parameter int unsigned SAVE_HALFWORDS = SAVE_HALFWORDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [WORD_W-1:0]      req_tdata,   // [31:0] bus_word
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [HALF_W-1:0]      rsp_tdata,   // [15:0] read_data
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [HALF_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(SAVE_HALFWORDS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAVE_HALFWORDS - 1);

   logic [HALF_W-1:0] header_first_ff, header_second_ff;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [WORD_W-1:0] s1_word_ff, s1_word_in, s2_word_ff, s3_word_ff;

   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  mod_rem;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_from_mem_ff;
   logic [HALF_W-1:0] rsp_hdr_ff, rsp_hdr_in;
   logic [HALF_W-1:0] mem_rd_data;
   logic              mem_busy;
   mem_ctl_type       mem_ctl;

   logic s3_is_wr, s3_is_rd;
   logic hit_first, hit_second, hit_save;
   logic s3_has_rsp, rsp_free, s3_take, s3_fire;
   logic s3_load, s2_load, s1_load;

   // Header CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RST;
         header_second_ff <= HEADER_SECOND_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata;
            CSR_HEADER_SECOND: header_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode the beat at the state stage
   assign s3_is_wr   = s3_word_ff[0];
   assign s3_is_rd   = (s3_word_ff == '0);
   assign hit_first  = (addr_ff == HDR_ADDR_FIRST);
   assign hit_second = (addr_ff == HDR_ADDR_SECOND);
   assign hit_save   = (addr_ff[31:27] == SAVE_TAG);
   assign s3_has_rsp = s3_is_rd && (hit_first || hit_second || hit_save);

   // Per-stage flow control; beats without an answer never wait on rsp
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s3_take    = !s3_has_rsp || rsp_free;
   assign s3_fire    = s3_valid_ff && s3_take;
   assign s3_load    = !s3_valid_ff || s3_take;
   assign s2_load    = !s2_valid_ff || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_tready = s1_load && !mem_busy;

   assign s1_word_in = {req_tdata[15:0], req_tdata[31:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= req_tvalid && req_tready;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_word_ff <= s1_word_in;
      if (s2_load) s2_word_ff <= s1_word_ff;
      if (s3_load) s3_word_ff <= s2_word_ff;
   end

   cbsr_mod_unit #(
      .DEPTH(SAVE_HALFWORDS)
   ) u_mod (
      .clock      (clock),
      .stage_a_en (s2_load),
      .stage_b_en (s3_load),
      .offset     (s1_word_ff[23:1]),
      .rem        (mod_rem)
   );

   // Address and index advance together; index is addr[23:1] mod depth
   always_comb begin
      addr_in = addr_ff;
      idx_in  = idx_ff;
      if (s3_fire) begin
         if (s3_is_wr || s3_is_rd) begin
            addr_in = addr_ff + ADDR_STEP;
            if ((&addr_ff[23:1]) || (idx_ff == IDX_LAST)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end else begin
            addr_in = s3_word_ff;
            idx_in  = mod_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         idx_ff  <= '0;
      end else begin
         addr_ff <= addr_in;
         idx_ff  <= idx_in;
      end
   end

   assign mem_ctl.wr_en = s3_fire && s3_is_wr;
   assign mem_ctl.rd_en = s3_fire && s3_is_rd && hit_save;

   cbsr_save_mem #(
      .DEPTH(SAVE_HALFWORDS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .idx     (idx_ff),
      .wr_data (s3_word_ff[31:16]),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   // Output register; hold while stalled
   assign rsp_hdr_in   = hit_first ? header_first_ff : header_second_ff;
   assign rsp_valid_in = (s3_fire && s3_has_rsp) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_fire && s3_has_rsp) begin
         rsp_from_mem_ff <= hit_save;
         rsp_hdr_ff      <= rsp_hdr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_from_mem_ff ? mem_rd_data : rsp_hdr_ff;

   `CBSR_ASSERT(a_no_accept_clear, mem_busy |-> !req_tready, "beat accepted during clear sweep")
   `CBSR_ASSERT(a_pipe_empty_clear, mem_busy |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff), "pipeline busy during clear sweep")
   `CBSR_ASSERT(a_idx_range, idx_ff <= IDX_LAST, "save index beyond memory depth")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for cartridge_bus_sram_responder: streams raw bus words in, mirrors
// the address latch, save memory and header registers, and checks every read beat.
// Depends on cbsr_pkg and the responder RTL.
`timescale 1ns / 100ps

module testbench import cbsr_pkg::*; ();

   localparam int unsigned SAVE_DEPTH = SAVE_HALFWORDS_DEF;
   localparam int SLOT_W = $clog2(SAVE_DEPTH);
   localparam logic [WORD_W-1:0] SAVE_LO = 32'h0800_0000;
   localparam logic [WORD_W-1:0] SAVE_HI = 32'h0FFF_FFFF;
   localparam logic [WORD_W-1:0] READ_WORD = 32'h0000_0000;
   localparam int PIPE_SETTLE = 8;
   localparam int PHASE_ITEMS = 260;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata = '0;    // [31:0] bus_word
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [HALF_W-1:0]      rsp_tdata;         // [15:0] read_data
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HEADER_FIRST;
   logic [HALF_W-1:0]      csr_wdata = '0;

   // mirrored block state
   logic [WORD_W-1:0] track_address = '0;
   logic [HALF_W-1:0] save_image [SAVE_DEPTH] = '{default: '0};
   logic [HALF_W-1:0] hdr_first_now = HEADER_FIRST_RST;
   logic [HALF_W-1:0] hdr_second_now = HEADER_SECOND_RST;

   logic [WORD_W-1:0] pending_words [$];
   logic [HALF_W-1:0] expected_halves [$];
   logic [HALF_W-1:0] want_half;
   logic              req_taken = 1'b0;
   logic              rsp_taken = 1'b0;
   logic              quiet_run = 1'b0;
   int unsigned       gap_left = 0;
   int unsigned       stall_left = 0;
   int unsigned       stall_draw;
   int                words_queued = 0;
   int                fail_count = 0;

   cartridge_bus_sram_responder #(
      .SAVE_HALFWORDS(SAVE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [WORD_W-1:0] bus_of(input logic [WORD_W-1:0] w);
      return {w[15:0], w[31:16]};
   endfunction

   function automatic logic [SLOT_W-1:0] save_slot(input logic [WORD_W-1:0] addr);
      return SLOT_W'(((addr & 32'h00FF_FFFF) >> 1) % SAVE_DEPTH);
   endfunction

   // Advance the mirrored state by one bus word and queue any read answer.
   function automatic void apply_bus_word(input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] w;
      w = bus_of(raw);
      if (w[0]) begin
         save_image[save_slot(track_address)] = w[31:16];
         track_address = track_address + ADDR_STEP;
      end else if (w != READ_WORD) begin
         track_address = w;
      end else begin
         if (track_address == HDR_ADDR_FIRST)
            expected_halves.push_back(hdr_first_now);
         else if (track_address == HDR_ADDR_SECOND)
            expected_halves.push_back(hdr_second_now);
         else if (track_address >= SAVE_LO && track_address <= SAVE_HI)
            expected_halves.push_back(save_image[save_slot(track_address)]);
         track_address = track_address + ADDR_STEP;
      end
   endfunction

   // Sample handshakes, check read beats, track accepted words and CSR writes.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_halves.size() == 0) begin
               $display("%0t: unexpected read_data, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want_half = expected_halves.pop_front();
               if (rsp_tdata !== want_half) begin
                  $display("%0t: read_data mismatch, expected %h, actual %h",
                           $time, want_half, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_bus_word(req_tdata);
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER_FIRST:  hdr_first_now = csr_wdata;
               CSR_HEADER_SECOND: hdr_second_now = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Request driver: one beat per pending word, random gap after each.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else if (req_tvalid && !req_taken) begin
         // hold the beat until accepted
      end else if (gap_left != 0) begin
         req_tvalid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_words.pop_front();
         gap_left <= quiet_run ? 0 : $urandom_range(0, 7);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response side: stall a random number of cycles after each taken beat.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_taken) begin
         stall_draw = quiet_run ? 0 : $urandom_range(0, 7);
         stall_left <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic drain_and_settle();
      while (pending_words.size() != 0 || req_tvalid || expected_halves.size() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_header(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [HALF_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_headers(input logic [HALF_W-1:0] first,
                              input logic [HALF_W-1:0] second);
      drain_and_settle();
      write_header(CSR_HEADER_FIRST, first);
      write_header(CSR_HEADER_SECOND, second);
   endtask

   // Latch an address, then a short run of reads, writes and the odd noise word.
   task automatic queue_random_run();
      logic [WORD_W-1:0] addr;
      logic [WORD_W-1:0] rnd;
      logic [WORD_W-1:0] payload;
      int unsigned pick;
      int unsigned run_len;
      rnd = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         addr = {SAVE_TAG, rnd[26:15], 14'(0) + 14'($urandom_range(0, 47)), 1'b0};
      else if (pick < 60)
         addr = {SAVE_TAG, rnd[26:1], 1'b0};
      else if (pick < 70)
         addr = HDR_ADDR_FIRST - (32'($urandom_range(0, 3)) << 1);
      else if (pick < 80)
         addr = {4'h1, rnd[27:1], 1'b0};
      else if (pick < 94)
         addr = {rnd[31:1], 1'b0};
      else
         addr = {28'hFFF_FFFF, rnd[3:1], 1'b0};
      if (addr == READ_WORD)
         addr = ADDR_STEP;
      quiet_run = ($urandom_range(0, 4) == 0);
      pending_words.push_back(bus_of(addr));
      run_len = $urandom_range(1, 8);
      repeat (run_len) begin
         pick = $urandom_range(0, 99);
         payload = $urandom;
         if (pick < 45)
            pending_words.push_back(READ_WORD);
         else if (pick < 90)
            pending_words.push_back(bus_of({payload[31:1], 1'b1}));
         else
            pending_words.push_back(payload);
      end
      words_queued += run_len + 1;
   endtask

   initial begin
      logic [WORD_W-1:0] directed_plan [26];
      logic [HALF_W-1:0] rand_first;
      logic [HALF_W-1:0] rand_second;
      int target;
      // swapped-form words: latches, reads (zero) and writes (bit 0 set)
      directed_plan = '{
         32'h0800_0000, READ_WORD, 32'hFFFF_FFFF, 32'h0800_0000, READ_WORD, READ_WORD,
         32'h0FFF_FFFE, READ_WORD, READ_WORD, READ_WORD, READ_WORD,
         32'h1FBF_FFFE, READ_WORD, 32'h07FF_FFFE, READ_WORD, READ_WORD,
         32'hFFFF_FFFE, READ_WORD, READ_WORD,
         32'hFFFF_FFFE, 32'h1234_0001,
         32'h0FFF_FFFE, READ_WORD, 32'h0000_0001, 32'h0800_8000, READ_WORD
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset header values, wrap at the top of memory and of the address space
      foreach (directed_plan[i])
         pending_words.push_back(bus_of(directed_plan[i]));
      words_queued += $size(directed_plan);

      for (int phase = 0; phase < 4; phase++) begin
         rand_first = HALF_W'($urandom);
         rand_second = HALF_W'($urandom);
         case (phase)
            0: set_headers(16'h0000, 16'hFFFF);
            1: set_headers(16'hFFFF, 16'h0000);
            default: set_headers(rand_first, rand_second);
         endcase
         target = words_queued + PHASE_ITEMS;
         while (words_queued < target)
            queue_random_run();
      end

      drain_and_settle();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // covers the post-reset memory sweep plus every item at its worst gaps
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
